// ----- src/ptsc_pkg.sv -----
// Shared types and constants for the task-graph scheduler.
// Used by the channel interfaces and the top level; depends on nothing.
package ptsc_pkg;

   // Largest task index the block handles
   localparam int PTSC_MAX_TASKS = 31;

   localparam int TASK_W = 5;
   localparam int DUR_W  = 8;
   localparam int TIME_W = 13;

   // Request operations
   localparam logic [1:0] OP_SET_DUR  = 2'd0;
   localparam logic [1:0] OP_ADD_EDGE = 2'd1;
   localparam logic [1:0] OP_RUN      = 2'd2;

   // Result kinds
   localparam logic [1:0] KIND_ORDER = 2'd0;
   localparam logic [1:0] KIND_CYCLE = 2'd1;
   localparam logic [1:0] KIND_PATH  = 2'd2;
   localparam logic [1:0] KIND_TOTAL = 2'd3;

   // DFS visit colors
   localparam logic [1:0] COLOR_WHITE = 2'd0;
   localparam logic [1:0] COLOR_GRAY  = 2'd1;
   localparam logic [1:0] COLOR_BLACK = 2'd2;

   typedef struct packed {
      logic [1:0]        operation;
      logic [TASK_W-1:0] task_req;
      logic [TASK_W-1:0] predecessor;
      logic [DUR_W-1:0]  duration;
   } req_word_type;

   typedef struct packed {
      logic [1:0]        kind;
      logic [TASK_W-1:0] task_id;
      logic [TIME_W-1:0] value;
      logic              last;
   } rsp_word_type;

endpackage

// ----- src/ptsc_if.sv -----
// Valid/ready channel interfaces for the scheduler's request and response words.
// Depends on ptsc_pkg for the word types.
interface ptsc_req_if import ptsc_pkg::*; ();
   logic         valid;
   logic         ready;
   req_word_type word;
   modport source (output valid, output word, input ready);
   modport sink   (input valid, input word, output ready);
endinterface

interface ptsc_rsp_if import ptsc_pkg::*; ();
   logic         valid;
   logic         ready;
   rsp_word_type word;
   modport source (output valid, output word, input ready);
   modport sink   (input valid, input word, output ready);
endinterface

// ----- src/pert_topo_sort_critical_path.sv -----
// Task-graph scheduler: DFS topological sort, cycle detection, critical path.
// Depends on ptsc_pkg and the channel interfaces in ptsc_if.sv.
//
// Usage: req_chan carries load and run words. A duration or edge word is taken
// while idle and produces nothing. A run word starts a sequencer that walks
// the graph depth first, one successor bit per cycle, then streams results on
// rsp_chan. On a cycle the members are sent, closing task first and last.
// Otherwise the topological order is sent, then each predecessor entry is
// relaxed in two steps (list RAM or leaf read, then add and compare), the
// critical path is traced back task by task (link check, then a list RAM read
// where the task has predecessors), and the path and total are sent.
// Results leave through one output register, one word per cycle when the sink
// keeps ready high; a stalled sink simply holds the sequencer. The last word of
// a run has last set. req_chan.ready is high only while the sequencer is idle.
// Reset (synchronous) empties the graph; the predecessor-list RAM is not
// cleared, since entries are only read below each task's fill count.
module pert_topo_sort_critical_path import ptsc_pkg::*; #(
   parameter int MAX_TASKS = PTSC_MAX_TASKS
) (
   input logic        clock,
   input logic        reset,
   ptsc_req_if.sink   req_chan,
   ptsc_rsp_if.source rsp_chan
);

   localparam int NW = $clog2(MAX_TASKS + 1);
   localparam int CW = $clog2(MAX_TASKS + 2);
   localparam int MEM_DEPTH = 1 << (2 * NW);
   localparam logic [CW-1:0] MAX_C  = CW'(MAX_TASKS);
   localparam logic [CW-1:0] LIST_C = CW'(MAX_TASKS + 1);

   typedef enum logic [11:0] {
      S_IDLE       = 12'h001,
      S_ROOT       = 12'h002,
      S_WALK       = 12'h004,
      S_EMIT_CYC   = 12'h008,
      S_EMIT_ORD   = 12'h010,
      S_RELAX_NEXT = 12'h020,
      S_RELAX_RD   = 12'h040,
      S_RELAX_CMP  = 12'h080,
      S_PATH_CHK   = 12'h100,
      S_PATH_RD    = 12'h200,
      S_EMIT_PATH  = 12'h400,
      S_EMIT_TOT   = 12'h800
   } state_type;

   // Graph storage
   logic [MAX_TASKS:0]    succ_ff  [MAX_TASKS:0];
   logic [CW-1:0]         cnt_ff   [MAX_TASKS:0];
   logic [DUR_W-1:0]      dur_ff   [MAX_TASKS:0];
   logic [MAX_TASKS:0]    present_ff;
   logic [NW-1:0]         pmem     [MEM_DEPTH];
   logic [NW-1:0]         mem_q;

   // Run storage
   logic [1:0]            color_ff [MAX_TASKS:0];
   logic [TIME_W-1:0]     fin_ff   [MAX_TASKS:0];
   logic [NW-1:0]         link_ff  [MAX_TASKS:0];
   logic [NW-1:0]         ws_node  [MAX_TASKS-1:0];
   logic [CW-1:0]         ws_next  [MAX_TASKS-1:0];
   logic [NW-1:0]         ord_stk  [MAX_TASKS-1:0];
   logic [NW-1:0]         cyc_stk  [MAX_TASKS:0];
   logic [NW-1:0]         leaf_stk [MAX_TASKS-1:0];
   logic [NW-1:0]         path_stk [MAX_TASKS-1:0];
   logic [NW-1:0]         leaf_q;

   // Sequencer registers
   state_type         state_ff, state_in;
   logic [CW-1:0]     root_ff, root_in;
   logic              pass_ff, pass_in;
   logic [NW-1:0]     top_node_ff, top_node_in;
   logic [CW-1:0]     top_next_ff, top_next_in;
   logic              top_leaf_ff, top_leaf_in;
   logic [NW-1:0]     sp_ff, sp_in;
   logic              cyc_found_ff, cyc_found_in;
   logic              cyc_closed_ff, cyc_closed_in;
   logic [NW-1:0]     cyc_head_ff, cyc_head_in;
   logic [CW-1:0]     cyc_cnt_ff, cyc_cnt_in;
   logic [CW-1:0]     ord_cnt_ff, ord_cnt_in;
   logic [CW-1:0]     leaf_cnt_ff, leaf_cnt_in;
   logic [CW-1:0]     idx_ff, idx_in;
   logic [NW-1:0]     tgt_ff, tgt_in;
   logic              tgt_sink_ff, tgt_sink_in;
   logic [CW-1:0]     pj_ff, pj_in;
   logic [CW-1:0]     pn_ff, pn_in;
   logic [TIME_W-1:0] best_ff, best_in;
   logic [NW-1:0]     bestp_ff, bestp_in;
   logic              have_ff, have_in;
   logic [TIME_W-1:0] sink_fin_ff, sink_fin_in;
   logic [NW-1:0]     sink_link_ff, sink_link_in;
   logic [NW-1:0]     cur_ff, cur_in;
   logic [CW-1:0]     len_ff, len_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_word_type      rsp_word_ff, rsp_word_in;

   // Write strobes for the arrays
   logic              run_go, dur_we, edge_we, pres_we;
   logic              color_we, fin_we, ws_we, ord_we, cyc_we, leaf_we, path_we;
   logic [NW-1:0]     color_idx, cyc_data;
   logic [1:0]        color_val;
   logic [NW-1:0]     ld_task, ld_pred, child, root_idx, p_sel;
   logic [CW-1:0]     idx_m1;
   logic [2*NW-1:0]   rd_addr;
   logic              out_free, scan_live, edge_bit, root_cand;
   logic [TIME_W-1:0] v_sum, best_nx;
   logic [NW-1:0]     bestp_nx;
   logic              take;
   req_word_type      rq;

   assign rq       = req_chan.word;
   assign ld_task  = rq.task_req[NW-1:0];
   assign ld_pred  = rq.predecessor[NW-1:0];
   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign idx_m1   = idx_ff - 1'b1;

   assign req_chan.ready = (state_ff == S_IDLE);
   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.word  = rsp_word_ff;

   // Walk step operands
   assign child     = top_next_ff[NW-1:0];
   assign scan_live = !cyc_found_ff && (top_next_ff <= MAX_C);
   assign edge_bit  = succ_ff[top_node_ff][child];
   assign root_idx  = root_ff[NW-1:0];
   assign root_cand = (pass_ff ? present_ff[root_idx] : succ_ff[0][root_idx])
                      && (color_ff[root_idx] == COLOR_WHITE);

   // Relax compare: finish of predecessor plus own duration, first max wins
   assign p_sel    = tgt_sink_ff ? leaf_q : mem_q;
   assign v_sum    = fin_ff[p_sel] + (tgt_sink_ff ? '0 : TIME_W'(dur_ff[tgt_ff]));
   assign take     = !have_ff || (v_sum > best_ff);
   assign best_nx  = take ? v_sum : best_ff;
   assign bestp_nx = take ? p_sel : bestp_ff;

   // List RAM read address: relax entry or first predecessor of path task
   assign rd_addr = (state_ff == S_RELAX_RD) ? {tgt_ff, pj_ff[NW-1:0]} : {cur_ff, NW'(0)};

   // Sequencer next state
   always_comb begin
      state_in      = state_ff;
      root_in       = root_ff;
      pass_in       = pass_ff;
      top_node_in   = top_node_ff;
      top_next_in   = top_next_ff;
      top_leaf_in   = top_leaf_ff;
      sp_in         = sp_ff;
      cyc_found_in  = cyc_found_ff;
      cyc_closed_in = cyc_closed_ff;
      cyc_head_in   = cyc_head_ff;
      cyc_cnt_in    = cyc_cnt_ff;
      ord_cnt_in    = ord_cnt_ff;
      leaf_cnt_in   = leaf_cnt_ff;
      idx_in        = idx_ff;
      tgt_in        = tgt_ff;
      tgt_sink_in   = tgt_sink_ff;
      pj_in         = pj_ff;
      pn_in         = pn_ff;
      best_in       = best_ff;
      bestp_in      = bestp_ff;
      have_in       = have_ff;
      sink_fin_in   = sink_fin_ff;
      sink_link_in  = sink_link_ff;
      cur_in        = cur_ff;
      len_in        = len_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_word_in   = rsp_word_ff;
      run_go   = 1'b0;
      dur_we   = 1'b0;
      edge_we  = 1'b0;
      pres_we  = 1'b0;
      color_we = 1'b0;
      color_idx = top_node_ff;
      color_val = COLOR_BLACK;
      fin_we   = 1'b0;
      ws_we    = 1'b0;
      ord_we   = 1'b0;
      cyc_we   = 1'b0;
      cyc_data = top_node_ff;
      leaf_we  = 1'b0;
      path_we  = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               if ((rq.operation == OP_SET_DUR || rq.operation == OP_ADD_EDGE)
                   && rq.task_req != '0 && rq.task_req <= TASK_W'(MAX_TASKS)) begin
                  if (rq.operation == OP_SET_DUR) begin
                     dur_we  = 1'b1;
                     pres_we = 1'b1;
                  end else if (rq.predecessor <= TASK_W'(MAX_TASKS)
                               && cnt_ff[ld_task] < LIST_C) begin
                     edge_we = 1'b1;
                     pres_we = 1'b1;
                  end
               end else if (rq.operation == OP_RUN) begin
                  run_go        = 1'b1;
                  root_in       = CW'(1);
                  pass_in       = 1'b0;
                  sp_in         = '0;
                  cyc_found_in  = 1'b0;
                  cyc_closed_in = 1'b0;
                  cyc_cnt_in    = '0;
                  ord_cnt_in    = '0;
                  leaf_cnt_in   = '0;
                  state_in      = S_ROOT;
               end
            end
         end

         // Pick the next DFS root: start successors first, then present tasks
         S_ROOT: begin
            if (cyc_found_ff || root_ff > MAX_C) begin
               if (!cyc_found_ff && !pass_ff) begin
                  pass_in = 1'b1;
                  root_in = CW'(1);
               end else if (cyc_found_ff) begin
                  idx_in   = cyc_cnt_ff;
                  state_in = S_EMIT_CYC;
               end else begin
                  idx_in   = ord_cnt_ff;
                  state_in = S_EMIT_ORD;
               end
            end else begin
               root_in = root_ff + 1'b1;
               if (root_cand) begin
                  top_node_in = root_idx;
                  top_next_in = '0;
                  top_leaf_in = 1'b1;
                  color_we    = 1'b1;
                  color_idx   = root_idx;
                  color_val   = COLOR_GRAY;
                  state_in    = S_WALK;
               end
            end
         end

         // One successor bit per cycle, or close the top frame
         S_WALK: begin
            if (scan_live) begin
               top_next_in = top_next_ff + 1'b1;
               if (edge_bit) begin
                  top_leaf_in = 1'b0;
                  if (color_ff[child] == COLOR_WHITE) begin
                     ws_we       = 1'b1;
                     sp_in       = sp_ff + 1'b1;
                     top_node_in = child;
                     top_next_in = '0;
                     top_leaf_in = 1'b1;
                     color_we    = 1'b1;
                     color_idx   = child;
                     color_val   = COLOR_GRAY;
                  end else if (color_ff[child] == COLOR_GRAY) begin
                     cyc_found_in = 1'b1;
                     cyc_head_in  = child;
                     cyc_we       = 1'b1;
                     cyc_data     = child;
                     cyc_cnt_in   = cyc_cnt_ff + 1'b1;
                  end
               end
            end else begin
               if (top_leaf_ff) begin
                  leaf_we     = 1'b1;
                  leaf_cnt_in = leaf_cnt_ff + 1'b1;
               end
               if (cyc_found_ff && !cyc_closed_ff) begin
                  cyc_we     = 1'b1;
                  cyc_cnt_in = cyc_cnt_ff + 1'b1;
                  if (top_node_ff == cyc_head_ff) cyc_closed_in = 1'b1;
               end
               color_we   = 1'b1;
               ord_we     = 1'b1;
               ord_cnt_in = ord_cnt_ff + 1'b1;
               if (sp_ff == '0) begin
                  state_in = S_ROOT;
               end else begin
                  top_node_in = ws_node[sp_ff - 1'b1];
                  top_next_in = ws_next[sp_ff - 1'b1];
                  top_leaf_in = 1'b0;
                  sp_in       = sp_ff - 1'b1;
               end
            end
         end

         S_EMIT_CYC: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_word_in  = '{kind: KIND_CYCLE, task_id: TASK_W'(cyc_stk[idx_m1[NW-1:0]]),
                                value: '0, last: (idx_ff == CW'(1))};
               idx_in = idx_m1;
               if (idx_ff == CW'(1)) state_in = S_IDLE;
            end
         end

         S_EMIT_ORD: begin
            if (idx_ff == '0) begin
               idx_in      = ord_cnt_ff;
               tgt_sink_in = 1'b0;
               state_in    = S_RELAX_NEXT;
            end else if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_word_in  = '{kind: KIND_ORDER, task_id: TASK_W'(ord_stk[idx_m1[NW-1:0]]),
                                value: '0, last: 1'b0};
               idx_in = idx_m1;
            end
         end

         // Choose the next task to relax in topological order, then the sink
         S_RELAX_NEXT: begin
            pj_in   = '0;
            have_in = 1'b0;
            if (idx_ff != '0) begin
               tgt_in = ord_stk[idx_m1[NW-1:0]];
               pn_in  = cnt_ff[ord_stk[idx_m1[NW-1:0]]];
               idx_in = idx_m1;
               if (cnt_ff[ord_stk[idx_m1[NW-1:0]]] != '0) state_in = S_RELAX_RD;
            end else if (!tgt_sink_ff) begin
               tgt_sink_in = 1'b1;
               pn_in       = leaf_cnt_ff;
               if (leaf_cnt_ff != '0) state_in = S_RELAX_RD;
            end else if (leaf_cnt_ff == '0) begin
               // no leaves: the project time is zero
               sink_fin_in = '0;
               len_in      = '0;
               idx_in      = '0;
               state_in    = S_EMIT_PATH;
            end else begin
               cur_in   = sink_link_ff;
               len_in   = '0;
               state_in = S_PATH_CHK;
            end
         end

         S_RELAX_RD: begin
            state_in = S_RELAX_CMP;
         end

         S_RELAX_CMP: begin
            best_in  = best_nx;
            bestp_in = bestp_nx;
            have_in  = 1'b1;
            pj_in    = pj_ff + 1'b1;
            if (pj_ff + 1'b1 == pn_ff) begin
               if (tgt_sink_ff) begin
                  sink_fin_in  = best_nx;
                  sink_link_in = bestp_nx;
               end else begin
                  fin_we = 1'b1;
               end
               state_in = S_RELAX_NEXT;
            end else begin
               state_in = S_RELAX_RD;
            end
         end

         // Trace links back until a task that starts from the project start
         S_PATH_CHK: begin
            if (len_ff < MAX_C && cur_ff != '0) begin
               path_we = 1'b1;
               len_in  = len_ff + 1'b1;
               if (cnt_ff[cur_ff] == '0) begin
                  idx_in   = len_ff + 1'b1;
                  state_in = S_EMIT_PATH;
               end else begin
                  state_in = S_PATH_RD;
               end
            end else begin
               idx_in   = len_ff;
               state_in = S_EMIT_PATH;
            end
         end

         S_PATH_RD: begin
            if (mem_q == '0) begin
               idx_in   = len_ff;
               state_in = S_EMIT_PATH;
            end else begin
               cur_in   = link_ff[cur_ff];
               state_in = S_PATH_CHK;
            end
         end

         S_EMIT_PATH: begin
            if (idx_ff == '0) begin
               state_in = S_EMIT_TOT;
            end else if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_word_in  = '{kind: KIND_PATH, task_id: TASK_W'(path_stk[idx_m1[NW-1:0]]),
                                value: TIME_W'(dur_ff[path_stk[idx_m1[NW-1:0]]]),
                                last: 1'b0};
               idx_in = idx_m1;
            end
         end

         S_EMIT_TOT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_word_in  = '{kind: KIND_TOTAL, task_id: '0, value: sink_fin_ff, last: 1'b1};
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_valid_ff  <= 1'b0;
         cyc_found_ff  <= 1'b0;
         cyc_closed_ff <= 1'b0;
         sp_ff         <= '0;
         cyc_cnt_ff    <= '0;
         ord_cnt_ff    <= '0;
         leaf_cnt_ff   <= '0;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         cyc_found_ff  <= cyc_found_in;
         cyc_closed_ff <= cyc_closed_in;
         sp_ff         <= sp_in;
         cyc_cnt_ff    <= cyc_cnt_in;
         ord_cnt_ff    <= ord_cnt_in;
         leaf_cnt_ff   <= leaf_cnt_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      root_ff      <= root_in;
      pass_ff      <= pass_in;
      top_node_ff  <= top_node_in;
      top_next_ff  <= top_next_in;
      top_leaf_ff  <= top_leaf_in;
      cyc_head_ff  <= cyc_head_in;
      idx_ff       <= idx_in;
      tgt_ff       <= tgt_in;
      tgt_sink_ff  <= tgt_sink_in;
      pj_ff        <= pj_in;
      pn_ff        <= pn_in;
      best_ff      <= best_in;
      bestp_ff     <= bestp_in;
      have_ff      <= have_in;
      sink_fin_ff  <= sink_fin_in;
      sink_link_ff <= sink_link_in;
      cur_ff       <= cur_in;
      len_ff       <= len_in;
      rsp_word_ff  <= rsp_word_in;
   end

   // Graph tables: successor bits, list fill counts, durations, presence
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= MAX_TASKS; i++) begin
            succ_ff[i] <= '0;
            cnt_ff[i]  <= '0;
            dur_ff[i]  <= '0;
         end
         present_ff <= '0;
      end else begin
         if (dur_we) dur_ff[ld_task] <= rq.duration;
         if (pres_we) present_ff[ld_task] <= 1'b1;
         if (edge_we) begin
            succ_ff[ld_pred][ld_task] <= 1'b1;
            cnt_ff[ld_task]           <= cnt_ff[ld_task] + 1'b1;
         end
      end
   end

   // Predecessor-list RAM: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (edge_we) pmem[{ld_task, cnt_ff[ld_task][NW-1:0]}] <= ld_pred;
      mem_q <= pmem[rd_addr];
   end

   // Visit colors and finish times, cleared at the start of each run
   always_ff @(posedge clock) begin
      if (reset || run_go) begin
         for (int i = 0; i <= MAX_TASKS; i++) begin
            color_ff[i] <= COLOR_WHITE;
            fin_ff[i]   <= '0;
         end
      end else begin
         if (color_we) color_ff[color_idx] <= color_val;
         if (fin_we) begin
            fin_ff[tgt_ff]  <= best_nx;
         end
      end
   end

   // Links and the stacks of the walk
   always_ff @(posedge clock) begin
      if (fin_we) link_ff[tgt_ff] <= bestp_nx;
      if (ws_we) begin
         ws_node[sp_ff] <= top_node_ff;
         ws_next[sp_ff] <= top_next_ff + 1'b1;
      end
      if (ord_we)  ord_stk[ord_cnt_ff[NW-1:0]]   <= top_node_ff;
      if (cyc_we)  cyc_stk[cyc_cnt_ff[NW-1:0]]   <= cyc_data;
      if (leaf_we) leaf_stk[leaf_cnt_ff[NW-1:0]] <= top_node_ff;
      if (path_we) path_stk[len_ff[NW-1:0]]      <= cur_ff;
      leaf_q <= leaf_stk[pj_ff[NW-1:0]];
   end

endmodule

// ----- verif/tb_pert_topo_sort_critical_path.sv -----
// Testbench for the task-graph scheduler: loads acyclic graphs, runs analyses,
// then closes cycles, checking every response word against a built-in predictor.
// Depends on ptsc_pkg, the channel interfaces and the top level in src.
module tb_pert_topo_sort_critical_path;
   import ptsc_pkg::*;

   localparam int NT      = PTSC_MAX_TASKS;
   localparam int SINK    = NT + 1;
   localparam int NNODES  = NT + 2;
   localparam int LISTLEN = NT + 1;
   localparam int MAXWORDS = 63;
   localparam int CYCLE_LIMIT = 2000000;

   // Schedule predictor and store of expected response words
   class schedule_scoreboard;
      logic [NNODES-1:0] succ [NT+1];
      int                plist [NNODES][LISTLEN];
      int                pcnt [NNODES];
      logic [DUR_W-1:0]  dur [NNODES];
      bit                present [NT+1];
      logic [1:0]        color [NNODES];
      logic [TIME_W-1:0] fin [NNODES];
      int                link [NNODES];
      bit                leaf [NNODES];
      int                wnode [NNODES];
      int                wnext [NNODES];
      int                depth;
      int                order [NNODES];
      int                ocnt;
      int                cyc [NNODES+1];
      int                ccnt;
      bit                found, closed;
      rsp_word_type      pending [$];
      int                errors;

      function new();
         for (int i = 0; i < NNODES; i++) begin
            pcnt[i] = 0;
            dur[i] = '0;
            if (i <= NT) begin
               succ[i] = '0;
               present[i] = 0;
            end
         end
         errors = 0;
      endfunction

      function void open_node(int u);
         wnode[depth] = u;
         wnext[depth] = 0;
         depth++;
         color[u] = COLOR_GRAY;
         leaf[u] = 1;
      endfunction

      function void walk(int root);
         int u, i;
         open_node(root);
         while (depth > 0) begin
            u = wnode[depth-1];
            i = wnext[depth-1];
            if (!found && i <= NT) begin
               wnext[depth-1] = i + 1;
               if (succ[u][i]) begin
                  leaf[u] = 0;
                  if (color[i] == COLOR_WHITE && depth < NNODES) open_node(i);
                  else if (color[i] == COLOR_GRAY) begin
                     found = 1;
                     if (ccnt < NNODES + 1) begin cyc[ccnt] = i; ccnt++; end
                  end
               end
               continue;
            end
            // finished node: leaves feed the sink
            if (leaf[u] && pcnt[SINK] < LISTLEN) begin
               succ[u][SINK] = 1'b1;
               plist[SINK][pcnt[SINK]] = u;
               pcnt[SINK]++;
            end
            if (found && !closed) begin
               if (ccnt < NNODES + 1) begin cyc[ccnt] = u; ccnt++; end
               if (u == cyc[0]) closed = 1;
            end
            color[u] = COLOR_BLACK;
            if (ocnt < NNODES) begin order[ocnt] = u; ocnt++; end
            depth--;
         end
      endfunction

      // Longest finish over predecessors; first listed wins ties
      function void relax(int a);
         logic [TIME_W-1:0] v;
         bit set;
         int p;
         set = 0;
         for (int j = 0; j < pcnt[a] && j < LISTLEN; j++) begin
            p = plist[a][j];
            v = fin[p] + dur[a];
            if (!set || v > fin[a]) begin
               fin[a] = v;
               link[a] = p;
               set = 1;
            end
         end
      endfunction

      function void add_word(ref rsp_word_type w [$], input logic [1:0] k, int id,
                             logic [TIME_W-1:0] val);
         rsp_word_type r;
         if (w.size() >= MAXWORDS) return;
         r.kind = k;
         r.task_id = id[TASK_W-1:0];
         r.value = val;
         r.last = 1'b0;
         w.push_back(r);
      endfunction

      function void run_analysis();
         rsp_word_type w [$];
         int path [NT];
         int len, cur;
         for (int i = 0; i < NNODES; i++) begin
            color[i] = COLOR_WHITE;
            fin[i] = '0;
            link[i] = 0;
            leaf[i] = 0;
         end
         depth = 0; ocnt = 0; ccnt = 0; found = 0; closed = 0;
         pcnt[SINK] = 0;
         for (int i = 0; i <= NT; i++) succ[i][SINK] = 1'b0;
         // start node's successors first, then every remaining task
         for (int i = 1; i <= NT && !found; i++)
            if (succ[0][i] && color[i] == COLOR_WHITE) walk(i);
         for (int i = 1; i <= NT && !found; i++)
            if (present[i] && color[i] == COLOR_WHITE) walk(i);
         if (found) begin
            for (int k = ccnt; k > 0; k--) add_word(w, KIND_CYCLE, cyc[k-1], '0);
         end else begin
            len = 0;
            for (int k = ocnt; k > 0; k--) add_word(w, KIND_ORDER, order[k-1], '0);
            for (int k = ocnt; k > 0; k--) relax(order[k-1]);
            relax(SINK);
            if (pcnt[SINK] > 0) begin
               cur = link[SINK];
               while (len < NT && cur >= 1 && cur <= NT) begin
                  path[len] = cur;
                  len++;
                  if (pcnt[cur] == 0 || plist[cur][0] == 0) break;
                  cur = link[cur];
               end
            end
            for (int k = len; k > 0; k--)
               add_word(w, KIND_PATH, path[k-1], TIME_W'(dur[path[k-1]]));
            add_word(w, KIND_TOTAL, 0, fin[SINK]);
         end
         if (w.size() > 0) w[w.size()-1].last = 1'b1;
         foreach (w[i]) pending.push_back(w[i]);
      endfunction

      // Accepted request word
      function void note_request(req_word_type q);
         int t, p;
         t = q.task_req;
         p = q.predecessor;
         if (q.operation == OP_SET_DUR || q.operation == OP_ADD_EDGE) begin
            if (t == 0 || t > NT) return;
            if (q.operation == OP_SET_DUR) begin
               dur[t] = q.duration;
               present[t] = 1;
            end else begin
               if (p > NT || pcnt[t] >= LISTLEN) return;
               succ[p][t] = 1'b1;
               plist[t][pcnt[t]] = p;
               pcnt[t]++;
               present[t] = 1;
            end
         end else if (q.operation == OP_RUN) run_analysis();
      endfunction

      // Accepted response word against the oldest expectation
      function void check_response(rsp_word_type a);
         rsp_word_type e;
         if (pending.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected word: kind %0d task %0d value %0d last %0d",
                                       a.kind, a.task_id, a.value, a.last);
            return;
         end
         e = pending.pop_front();
         if (a.kind !== e.kind || a.task_id !== e.task_id || a.value !== e.value ||
             a.last !== e.last) begin
            errors++;
            if (errors <= 10)
               $display({"word mismatch: exp kind %0d task %0d value %0d last %0d,",
                         " got %0d %0d %0d %0d"},
                        e.kind, e.task_id, e.value, e.last, a.kind, a.task_id, a.value, a.last);
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   int   cycles = 0;
   int   rsp_stall;
   bit   rsp_steady;

   ptsc_req_if req_chan ();
   ptsc_rsp_if rsp_chan ();

   pert_topo_sort_critical_path dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source)
   );

   schedule_scoreboard board = new();

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Response side: check and random stalls, with stall-free stretches
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         rsp_stall = 0;
         rsp_steady = 0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            board.check_response(rsp_chan.word);
            if ($urandom_range(0, 29) == 0) rsp_steady = ~rsp_steady;
            rsp_stall = rsp_steady ? 0 : $urandom_range(0, 10);
         end
         if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_chan.ready <= 1'b0;
         end else rsp_chan.ready <= 1'b1;
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   task automatic send_word(logic [1:0] op, int t, int p, int d);
      int gap;
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.word <= '{operation: op, task_req: t[TASK_W-1:0],
                         predecessor: p[TASK_W-1:0], duration: d[DUR_W-1:0]};
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      board.note_request(req_chan.word);
   endtask

   task automatic drain();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (board.pending.size() > 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   initial begin
      int t, r;
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.word = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty graph, extremes, ignored words, tie, isolated task
      send_word(OP_RUN, 0, 0, 0);
      send_word(OP_SET_DUR, 1, 0, 255);
      send_word(OP_SET_DUR, 2, 31, 0);
      send_word(OP_ADD_EDGE, 1, 0, 0);
      send_word(OP_ADD_EDGE, 2, 1, 255);
      send_word(OP_ADD_EDGE, 3, 1, 0);
      send_word(OP_SET_DUR, 0, 5, 77);
      send_word(OP_ADD_EDGE, 0, 3, 9);
      send_word(2'd3, 7, 7, 7);
      send_word(OP_SET_DUR, 31, 0, 128);
      send_word(OP_RUN, 31, 31, 255);
      send_word(OP_SET_DUR, 4, 0, 10);
      send_word(OP_ADD_EDGE, 4, 3, 0);
      send_word(OP_ADD_EDGE, 4, 2, 0);
      send_word(OP_ADD_EDGE, 4, 3, 0);
      send_word(OP_ADD_EDGE, 30, 4, 0);
      send_word(OP_SET_DUR, 30, 0, 1);
      send_word(OP_RUN, 0, 0, 0);
      send_word(OP_RUN, 0, 0, 0);
      drain();

      // overfill one predecessor list
      for (int i = 0; i < 34; i++) send_word(OP_ADD_EDGE, 29, $urandom_range(0, 28), 0);

      // random acyclic loading with runs; edges only go upward in index
      for (int n = 0; n < 120; n++) begin
         r = $urandom_range(0, 99);
         t = $urandom_range(1, NT);
         if (r < 35) send_word(OP_SET_DUR, t, $urandom_range(0, 31),
                               $urandom_range(0, 3) == 0 ? 255 * $urandom_range(0, 1)
                                                         : $urandom_range(0, 255));
         else if (r < 88) send_word(OP_ADD_EDGE, t, $urandom_range(0, t - 1),
                                    $urandom_range(0, 255));
         else if (r < 96) send_word(OP_RUN, t, $urandom_range(0, 31), $urandom_range(0, 255));
         else send_word($urandom_range(0, 1) ? 2'd3 : OP_SET_DUR, 0,
                        $urandom_range(0, 31), $urandom_range(0, 255));
         if (n % 70 == 69) drain();
      end
      send_word(OP_RUN, 0, 0, 0);
      drain();

      // close cycles: backward edges, a self loop, then runs
      send_word(OP_ADD_EDGE, 1, 2, 0);
      send_word(OP_RUN, 0, 0, 0);
      for (int n = 0; n < 12; n++) begin
         send_word(OP_ADD_EDGE, $urandom_range(1, NT), $urandom_range(0, 31), 0);
         send_word(OP_RUN, 0, 0, 0);
      end
      send_word(OP_ADD_EDGE, 17, 17, 0);
      send_word(OP_RUN, 0, 0, 0);
      drain();

      if (board.errors == 0 && board.pending.size() == 0) $display("SCOREBOARD CLEAN");
      else $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

// ----- sim.f -----
src/ptsc_pkg.sv
src/ptsc_if.sv
src/pert_topo_sort_critical_path.sv
verif/tb_pert_topo_sort_critical_path.sv
